// File: src/stt_pkg.sv
// Shared types, character codes and character-class helpers for the source text tokenizer.
// No dependencies; stt_step, stt_queue and the top level use this package.
`timescale 1ns / 1ps
`default_nettype none

package stt_pkg;

  // Character codes
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_AMP    = 8'h26;
  localparam logic [7:0] CH_EQ     = 8'h3D;
  localparam logic [7:0] CH_BAR    = 8'h7C;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_PCT    = 8'h25;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_BANG   = 8'h21;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;

  localparam logic [15:0] LINE_MAX        = 16'hFFFF;
  localparam logic [15:0] FIRST_LINE_INIT = 16'd1;

  // Token kinds as they appear on the result channel
  localparam logic [2:0] KIND_NUMBER = 3'd0;
  localparam logic [2:0] KIND_OPER   = 3'd1;
  localparam logic [2:0] KIND_STRING = 3'd2;
  localparam logic [2:0] KIND_IDENT  = 3'd3;
  localparam logic [2:0] KIND_END    = 3'd4;

  // Input command codes
  localparam logic CMD_CHAR = 1'b0;
  localparam logic CMD_END  = 1'b1;

  typedef enum logic [2:0] {
    MODE_IDLE   = 3'd0,
    MODE_NUMBER = 3'd1,
    MODE_DOT    = 3'd2,
    MODE_OPER   = 3'd3,
    MODE_STRING = 3'd4,
    MODE_IDENT  = 3'd5
  } mode_t;

  typedef struct packed {
    mode_t       mode;
    logic [7:0]  held_char;
    logic        held_valid;
    logic        held_starts;
    logic [15:0] line_count;
  } scan_state_t;

  typedef struct packed {
    logic [7:0]  out_char;
    logic        char_valid;
    logic [2:0]  token_kind;
    logic        token_start;
    logic        token_end;
    logic        unterminated;
    logic [15:0] line_number;
    logic        last;
  } result_t;

  // Results of one transfer: up to two, in order r0 then r1
  typedef struct packed {
    logic [1:0] cnt;
    result_t    r0;
    result_t    r1;
  } push_t;

  function automatic logic is_space(input logic [7:0] c);
    return c inside {CH_SPACE, CH_TAB, CH_LF, CH_CR};
  endfunction

  function automatic logic is_quote(input logic [7:0] c);
    return c inside {CH_DQUOTE, CH_SQUOTE};
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c inside {[CH_ZERO:CH_NINE]};
  endfunction

  function automatic logic is_num_body(input logic [7:0] c);
    return is_digit(c) || (c == CH_DOT);
  endfunction

  function automatic logic is_op_byte(input logic [7:0] c);
    return c inside {CH_SEMI, CH_COMMA, CH_LPAREN, CH_RPAREN, CH_PLUS, CH_MINUS,
                     CH_STAR, CH_SLASH, CH_PCT, CH_EQ, CH_GT, CH_LT, CH_BANG,
                     CH_AMP, CH_BAR, CH_LBRACE, CH_RBRACE, CH_DOT, CH_LBRACK,
                     CH_RBRACK};
  endfunction

  function automatic logic pair_first(input logic [7:0] c);
    return c inside {CH_AMP, CH_BANG, CH_BAR, CH_PLUS, CH_MINUS, CH_STAR,
                     CH_SLASH, CH_LT, CH_GT, CH_EQ};
  endfunction

  function automatic logic pair_second(input logic [7:0] c);
    return c inside {CH_AMP, CH_EQ, CH_BAR, CH_PLUS, CH_MINUS};
  endfunction

endpackage

`default_nettype wire

// File: src/stt_ifs.sv
// Channel interfaces of the source text tokenizer: text input, result output, config write.
// Depends on nothing; payload widths follow the block's field list.
`timescale 1ns / 1ps
`default_nettype none

interface stt_in_if;
  logic       valid;
  logic       ready;
  logic       command;
  logic [7:0] char_code;

  modport source (output valid, output command, output char_code, input ready);
  modport sink   (input valid, input command, input char_code, output ready);
endinterface

interface stt_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  out_char;
  logic        char_valid;
  logic [2:0]  token_kind;
  logic        token_start;
  logic        token_end;
  logic        unterminated;
  logic [15:0] line_number;
  logic        last;

  modport source (output valid, output out_char, output char_valid, output token_kind,
                  output token_start, output token_end, output unterminated,
                  output line_number, output last, input ready);
  modport sink   (input valid, input out_char, input char_valid, input token_kind,
                  input token_start, input token_end, input unterminated,
                  input line_number, input last, output ready);
endinterface

interface stt_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// File: src/stt_step.sv
// Next-state and result logic for one input transfer of the tokenizer.
// Depends on stt_pkg for state, result types and character classes.
`timescale 1ns / 1ps
`default_nettype none

module stt_step (
  input  stt_pkg::scan_state_t st,
  input  logic                 command,
  input  logic [7:0]           char_code,
  input  logic [15:0]          first_line,
  output stt_pkg::scan_state_t st_nxt,
  output stt_pkg::push_t       push
);

  function automatic stt_pkg::result_t mk(input logic [7:0] ch, input logic v,
                                          input logic [2:0] k, input logic s,
                                          input logic e, input logic u,
                                          input logic [15:0] ln);
    stt_pkg::result_t r;
    r.out_char     = v ? ch : 8'h00;
    r.char_valid   = v;
    r.token_kind   = k;
    r.token_start  = s;
    r.token_end    = e;
    r.unterminated = u;
    r.line_number  = ln;
    r.last         = 1'b0;
    return r;
  endfunction

  function automatic stt_pkg::scan_state_t cleared(input logic [15:0] ln);
    stt_pkg::scan_state_t s;
    s.mode        = stt_pkg::MODE_IDLE;
    s.held_char   = 8'h00;
    s.held_valid  = 1'b0;
    s.held_starts = 1'b0;
    s.line_count  = ln;
    return s;
  endfunction

  function automatic stt_pkg::scan_state_t held(input stt_pkg::mode_t md, input logic [7:0] c,
                                                input logic starts, input logic [15:0] ln);
    stt_pkg::scan_state_t s;
    s.mode        = md;
    s.held_char   = c;
    s.held_valid  = 1'b1;
    s.held_starts = starts;
    s.line_count  = ln;
    return s;
  endfunction

  logic [7:0]           c;
  logic [7:0]           h;
  logic                 hs;
  logic [15:0]          ln;
  stt_pkg::scan_state_t b_st;
  logic                 b_v;
  stt_pkg::result_t     b_r;
  logic                 pre_v;
  logic                 post_v;
  stt_pkg::result_t     pre_r;
  stt_pkg::result_t     post_r;
  logic                 ident_go;

  assign c  = char_code;
  assign h  = st.held_char;
  assign hs = st.held_starts;
  assign ln = st.line_count;
  assign ident_go = !stt_pkg::is_space(c) && !stt_pkg::is_op_byte(c) && !stt_pkg::is_quote(c);

  // Start a token from the incoming byte, as if between tokens
  always_comb begin
    b_st = cleared(ln);
    b_v  = 1'b0;
    b_r  = mk(c, 1'b1, stt_pkg::KIND_OPER, 1'b1, 1'b1, 1'b0, ln);
    if (stt_pkg::is_space(c)) begin
      if (c == stt_pkg::CH_LF && ln != stt_pkg::LINE_MAX) begin
        b_st.line_count = ln + 16'd1;
      end
    end else if (stt_pkg::is_digit(c)) begin
      b_st = held(stt_pkg::MODE_NUMBER, c, 1'b1, ln);
    end else if (c == stt_pkg::CH_DOT) begin
      b_st = held(stt_pkg::MODE_DOT, c, 1'b1, ln);
    end else if (stt_pkg::is_op_byte(c)) begin
      if (stt_pkg::pair_first(c)) begin
        b_st = held(stt_pkg::MODE_OPER, c, 1'b1, ln);
      end else begin
        b_v = 1'b1;
      end
    end else if (stt_pkg::is_quote(c)) begin
      b_st.mode        = stt_pkg::MODE_STRING;
      b_st.held_starts = 1'b1;
    end else begin
      b_st = held(stt_pkg::MODE_IDENT, c, 1'b1, ln);
    end
  end

  // Close or extend the held token; pre is the held byte, post what follows it
  always_comb begin
    pre_v  = 1'b0;
    pre_r  = mk(h, 1'b1, stt_pkg::KIND_NUMBER, hs, 1'b1, 1'b0, ln);
    post_v = b_v;
    post_r = b_r;
    st_nxt = b_st;
    if (command == stt_pkg::CMD_END) begin
      post_v = 1'b1;
      post_r = mk(8'h00, 1'b0, stt_pkg::KIND_END, 1'b1, 1'b1,
                  st.mode == stt_pkg::MODE_STRING, ln);
      st_nxt = cleared(first_line);
      case (st.mode)
        stt_pkg::MODE_NUMBER: begin
          pre_v = 1'b1;
        end
        stt_pkg::MODE_IDENT: begin
          pre_v = 1'b1;
          pre_r = mk(h, 1'b1, stt_pkg::KIND_IDENT, hs, 1'b1, 1'b0, ln);
        end
        stt_pkg::MODE_DOT, stt_pkg::MODE_OPER: begin
          pre_v = 1'b1;
          pre_r = mk(h, 1'b1, stt_pkg::KIND_OPER, 1'b1, 1'b1, 1'b0, ln);
        end
        default: begin
          pre_v = 1'b0;
        end
      endcase
    end else begin
      case (st.mode)
        stt_pkg::MODE_NUMBER: begin
          pre_v = 1'b1;
          pre_r = mk(h, 1'b1, stt_pkg::KIND_NUMBER, hs, !stt_pkg::is_num_body(c), 1'b0, ln);
          if (stt_pkg::is_num_body(c)) begin
            post_v = 1'b0;
            st_nxt = held(stt_pkg::MODE_NUMBER, c, 1'b0, ln);
          end
        end
        stt_pkg::MODE_DOT: begin
          pre_v = 1'b1;
          if (stt_pkg::is_num_body(c)) begin
            pre_r  = mk(h, 1'b1, stt_pkg::KIND_NUMBER, 1'b1, 1'b0, 1'b0, ln);
            post_v = 1'b0;
            st_nxt = held(stt_pkg::MODE_NUMBER, c, 1'b0, ln);
          end else begin
            pre_r = mk(h, 1'b1, stt_pkg::KIND_OPER, 1'b1, 1'b1, 1'b0, ln);
          end
        end
        stt_pkg::MODE_OPER: begin
          pre_v = 1'b1;
          if (stt_pkg::pair_second(c)) begin
            pre_r  = mk(h, 1'b1, stt_pkg::KIND_OPER, 1'b1, 1'b0, 1'b0, ln);
            post_v = 1'b1;
            post_r = mk(c, 1'b1, stt_pkg::KIND_OPER, 1'b0, 1'b1, 1'b0, ln);
            st_nxt = cleared(ln);
          end else begin
            pre_r = mk(h, 1'b1, stt_pkg::KIND_OPER, 1'b1, 1'b1, 1'b0, ln);
          end
        end
        stt_pkg::MODE_STRING: begin
          post_v = 1'b0;
          if (stt_pkg::is_quote(c)) begin
            // Closing quote; an empty string still gives one result
            pre_v = 1'b1;
            if (st.held_valid) begin
              pre_r = mk(h, 1'b1, stt_pkg::KIND_STRING, hs, 1'b1, 1'b0, ln);
            end else begin
              pre_r = mk(8'h00, 1'b0, stt_pkg::KIND_STRING, 1'b1, 1'b1, 1'b0, ln);
            end
            st_nxt = cleared(ln);
          end else begin
            pre_v  = st.held_valid;
            pre_r  = mk(h, 1'b1, stt_pkg::KIND_STRING, hs, 1'b0, 1'b0, ln);
            st_nxt = held(stt_pkg::MODE_STRING, c, !st.held_valid, ln);
          end
        end
        stt_pkg::MODE_IDENT: begin
          pre_v = 1'b1;
          pre_r = mk(h, 1'b1, stt_pkg::KIND_IDENT, hs, !ident_go, 1'b0, ln);
          if (ident_go) begin
            post_v = 1'b0;
            st_nxt = held(stt_pkg::MODE_IDENT, c, 1'b0, ln);
          end
        end
        default: begin
          pre_v = 1'b0;
        end
      endcase
    end
  end

  // Pack results in order and mark the final one
  always_comb begin
    push.r0 = pre_v ? pre_r : post_r;
    push.r1 = post_r;
    if (pre_v && post_v) begin
      push.cnt = 2'd2;
    end else if (pre_v || post_v) begin
      push.cnt = 2'd1;
    end else begin
      push.cnt = 2'd0;
    end
    push.r0.last = (push.cnt == 2'd1);
    push.r1.last = 1'b1;
  end

endmodule

`default_nettype wire

// File: src/stt_queue.sv
// Result queue of the tokenizer: takes up to two results per cycle, hands out one.
// Depends on stt_pkg for the result and push types.
`timescale 1ns / 1ps
`default_nettype none

module stt_queue #(
  parameter int DEPTH = 4
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  stt_pkg::push_t               push,
  input  logic                         pop,
  output stt_pkg::result_t             head,
  output logic [$clog2(DEPTH+1)-1:0]   level
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int LVL_W = $clog2(DEPTH + 1);

  function automatic logic [PTR_W-1:0] inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  stt_pkg::result_t   mem_r [DEPTH];
  logic [PTR_W-1:0]   wp_r;
  logic [PTR_W-1:0]   rp_r;
  logic [LVL_W-1:0]   cnt_r;
  logic [PTR_W-1:0]   wp1;
  logic [PTR_W-1:0]   wp2;
  logic [PTR_W-1:0]   wp_nxt;

  assign wp1 = inc(wp_r);
  assign wp2 = inc(wp1);

  always_comb begin
    case (push.cnt)
      2'd1:    wp_nxt = wp1;
      2'd2:    wp_nxt = wp2;
      default: wp_nxt = wp_r;
    endcase
  end

  // Store results in arrival order
  always_ff @(posedge clk) begin
    if (push.cnt != 2'd0) begin
      mem_r[wp_r] <= push.r0;
    end
    if (push.cnt == 2'd2) begin
      mem_r[wp1] <= push.r1;
    end
  end

  // Advance pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= pop ? inc(rp_r) : rp_r;
      cnt_r <= cnt_r + LVL_W'(push.cnt) - LVL_W'(pop);
    end
  end

  assign head  = mem_r[rp_r];
  assign level = cnt_r;

endmodule

`default_nettype wire

// File: src/source_text_tokenizer.sv
// Top level of the source text tokenizer: scan state, config register, result queue.
// Depends on stt_pkg, the channel interfaces, stt_step and stt_queue.
//
//   channel   dir  payload                                   transfer when
//   in_chan   in   command, char_code                        valid && ready
//   out_chan  out  out_char .. line_number, last             valid && ready
//   cfg_chan  in   data = first_line (16 bits)               valid && ready
//
// One text byte or end-of-text item is taken per cycle while in_chan.ready is high;
// its results are written into the queue at the transfer edge and can leave from the
// next cycle, one per cycle while out_chan.ready is high. in_chan.ready is high while
// the queue has room for two results (level at most QUEUE_DEPTH-2).
// Reset is synchronous and active low; first_line returns to 1.
// Output stalls fill the queue and then hold in_chan.ready low until it drains.
`timescale 1ns / 1ps
`default_nettype none

module source_text_tokenizer #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst_n,
  stt_in_if.sink     in_chan,
  stt_out_if.source  out_chan,
  stt_cfg_if.sink    cfg_chan
);

  localparam int LVL_W = $clog2(QUEUE_DEPTH + 1);

  stt_pkg::scan_state_t state_r;
  stt_pkg::scan_state_t state_nxt;
  stt_pkg::scan_state_t step_st;
  logic [15:0]          first_line_r;
  stt_pkg::push_t       step_push;
  stt_pkg::push_t       q_push;
  stt_pkg::result_t     head;
  logic [LVL_W-1:0]     level;
  logic                 in_acc;
  logic                 cfg_acc;
  logic                 pop;

  assign in_chan.ready  = (level <= LVL_W'(QUEUE_DEPTH - 2));
  assign cfg_chan.ready = 1'b1;
  assign in_acc  = in_chan.valid && in_chan.ready;
  assign cfg_acc = cfg_chan.valid && cfg_chan.ready;
  assign pop     = out_chan.valid && out_chan.ready;

  stt_step u_step (
    .st         (state_r),
    .command    (in_chan.command),
    .char_code  (in_chan.char_code),
    .first_line (first_line_r),
    .st_nxt     (step_st),
    .push       (step_push)
  );

  // Push results only on an input transfer
  always_comb begin
    q_push = step_push;
    if (!in_acc) begin
      q_push.cnt = 2'd0;
    end
  end

  stt_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .pop   (pop),
    .head  (head),
    .level (level)
  );

  // Advance on an input transfer; a config write reloads the line count
  always_comb begin
    state_nxt = state_r;
    if (in_acc) begin
      state_nxt = step_st;
    end
    if (cfg_acc) begin
      state_nxt.line_count = cfg_chan.data;
    end
  end

  // Hold scan state and the first-line register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= '{mode: stt_pkg::MODE_IDLE, held_char: 8'h00, held_valid: 1'b0,
                        held_starts: 1'b0, line_count: stt_pkg::FIRST_LINE_INIT};
      first_line_r <= stt_pkg::FIRST_LINE_INIT;
    end else begin
      state_r <= state_nxt;
      if (cfg_acc) begin
        first_line_r <= cfg_chan.data;
      end
    end
  end

  // Drive the result channel from the queue head
  assign out_chan.valid        = (level != '0);
  assign out_chan.out_char     = head.out_char;
  assign out_chan.char_valid   = head.char_valid;
  assign out_chan.token_kind   = head.token_kind;
  assign out_chan.token_start  = head.token_start;
  assign out_chan.token_end    = head.token_end;
  assign out_chan.unterminated = head.unterminated;
  assign out_chan.line_number  = head.line_number;
  assign out_chan.last         = head.last;

`ifndef SYNTH
  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    level <= LVL_W'(QUEUE_DEPTH))
    else $error("result queue overfilled");

  a_end_resets: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_chan.command == stt_pkg::CMD_END) |=>
      (state_r.mode == stt_pkg::MODE_IDLE && state_r.line_count == first_line_r))
    else $error("end of text did not return scanner to idle");

  a_held_mode: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.held_valid |-> state_r.mode != stt_pkg::MODE_IDLE)
    else $error("held byte while between tokens");

  a_empty_char: assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && !out_chan.char_valid) |-> out_chan.out_char == 8'h00)
    else $error("byte shown on a result without content");
`endif

endmodule

`default_nettype wire
